// File: hw/rtl/isa_pkg.sv
// Shared codes and the per-cell control bundle for the indexed shift array.
package isa_pkg;

  localparam logic [2:0] FN_INSERT = 3'd0;
  localparam logic [2:0] FN_DELETE = 3'd1;
  localparam logic [2:0] FN_READ   = 3'd2;
  localparam logic [2:0] FN_FIND   = 3'd3;
  localparam logic [2:0] FN_ROTL   = 3'd4;
  localparam logic [2:0] FN_ROTR   = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOB  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // next-value source of one cell
  localparam logic [2:0] SEL_HOLD  = 3'd0;
  localparam logic [2:0] SEL_VALUE = 3'd1;
  localparam logic [2:0] SEL_LOWER = 3'd2;
  localparam logic [2:0] SEL_UPPER = 3'd3;
  localparam logic [2:0] SEL_WRAP  = 3'd4;

  typedef struct packed {
    logic [2:0] sel;
    logic       rd_tap;
    logic       last_tap;
    logic       live;
  } cell_ctl_t;

endpackage

// File: hw/rtl/isa_cell.sv
// One storage cell of the array: holds an entry, shifts with its neighbors, joins the
// read, last-entry and find chains.
module isa_cell import isa_pkg::*; #(
  parameter int WIDTH  = 32,
  parameter int FIDX_W = 4,
  parameter int IDX    = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [WIDTH-1:0]  value,
  input  logic [WIDTH-1:0]  lower,
  input  logic [WIDTH-1:0]  upper,
  input  logic [WIDTH-1:0]  wrap,
  input  logic [WIDTH-1:0]  mask,
  input  logic [WIDTH-1:0]  rd_in,
  output logic [WIDTH-1:0]  rd_out,
  input  logic [WIDTH-1:0]  last_in,
  output logic [WIDTH-1:0]  last_out,
  input  logic              hit_in,
  input  logic [FIDX_W-1:0] hit_idx_in,
  output logic              hit_out,
  output logic [FIDX_W-1:0] hit_idx_out,
  output logic [WIDTH-1:0]  data
);

  localparam logic [FIDX_W-1:0] MY_IDX = FIDX_W'(IDX);

  logic [WIDTH-1:0] data_next;
  logic             match;

  always_comb begin
    case (ctl.sel)
      SEL_HOLD:  data_next = data;
      SEL_VALUE: data_next = value;
      SEL_LOWER: data_next = lower;
      SEL_UPPER: data_next = upper;
      SEL_WRAP:  data_next = wrap;
      default:   data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // value doubles as the search key
  assign match = ctl.live && (((data ^ value) & mask) == '0);

  // lower cells override upper ones, so the lowest match wins
  assign hit_out     = match | hit_in;
  assign hit_idx_out = match ? MY_IDX : hit_idx_in;
  assign rd_out      = ctl.rd_tap ? data : rd_in;
  assign last_out    = ctl.last_tap ? data : last_in;

endmodule

// File: hw/rtl/indexed_shift_array.sv
// Top level of the indexed shift array: request decode, cell row and result register.
//
//  channel | direction | handshake                      | payload
//  s_axis  | in        | s_axis_tvalid / s_axis_tready  | tdata: func, index, value
//  m_axis  | out       | m_axis_tvalid / m_axis_tready  | tdata: status, read_value,
//          |           |                                |   found, found_index, count
//  cfg     | in        | cfg_wr_en                      | cfg_wr_data: compare_mask
//
// One request per cycle unless m_axis stalls: every cell updates in the accepting cycle and
// the result is registered, appearing in the cycle after acceptance. The read, last-entry and
// find chains run through all DEPTH cells in the accepting cycle and set the clock period.
// Reset clears the entry count, the result valid and sets compare_mask to all ones.
// A stalled result holds in the output register; a new request is taken in the same
// cycle the pending result leaves.
module indexed_shift_array import isa_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // bits from 0: func[3], index[IDX_W], value[WIDTH], zero fill
  input  logic [((3 + $clog2(DEPTH + 1) + WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // bits from 0: status[2], read_value[WIDTH], found[1], found_index[FIDX_W],
  // count[IDX_W], zero fill
  output logic [((3 + WIDTH + $clog2(DEPTH) + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                               m_axis_tdata,
  input  logic                 cfg_wr_en,
  input  logic [WIDTH-1:0]     cfg_wr_data
);

  localparam int IDX_W   = $clog2(DEPTH + 1);
  localparam int FIDX_W  = $clog2(DEPTH);
  localparam int OUT_BITS = 2 + WIDTH + 1 + FIDX_W + IDX_W;
  localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;
  localparam logic [IDX_W:0] DEPTH_EXT = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W:0] ONE_EXT   = (IDX_W + 1)'(1);

  logic [2:0]       func;
  logic [IDX_W-1:0] pos;
  logic [WIDTH-1:0] value;
  logic             accept;

  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] count_next;
  logic [WIDTH-1:0] compare_mask;

  logic [IDX_W:0]   cnt_ext;
  logic [IDX_W:0]   pos_ext;
  logic             ins_ok;
  logic             del_ok;
  logic             rot_ok;
  logic [1:0]       status_next;

  logic [WIDTH-1:0]  cell_data [DEPTH];
  logic [WIDTH-1:0]  rd_chain   [DEPTH+1];
  logic [WIDTH-1:0]  last_chain [DEPTH+1];
  logic              hit_chain  [DEPTH+1];
  logic [FIDX_W-1:0] hidx_chain [DEPTH+1];
  logic [WIDTH-1:0]  wrap;
  cell_ctl_t         ctl [DEPTH];

  logic              out_valid;
  logic [1:0]        out_status;
  logic [WIDTH-1:0]  out_rd;
  logic              out_found;
  logic [FIDX_W-1:0] out_fidx;
  logic [IDX_W-1:0]  out_count;

  assign func  = s_axis_tdata[2:0];
  assign pos   = s_axis_tdata[3 +: IDX_W];
  assign value = s_axis_tdata[3 + IDX_W +: WIDTH];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cnt_ext = {1'b0, count};
  assign pos_ext = {1'b0, pos};
  assign ins_ok  = (func == FN_INSERT) && (pos_ext <= cnt_ext) && (cnt_ext < DEPTH_EXT);
  assign del_ok  = (func == FN_DELETE) && (pos_ext < cnt_ext);
  assign rot_ok  = ((func == FN_ROTL) || (func == FN_ROTR)) && (cnt_ext > ONE_EXT);

  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    case (func)
      FN_INSERT: begin
        if (pos_ext > cnt_ext) status_next = ST_OOB;
        else if (cnt_ext >= DEPTH_EXT) status_next = ST_FULL;
        else count_next = count + IDX_W'(1);
      end
      FN_DELETE: begin
        if (pos_ext >= cnt_ext) status_next = ST_OOB;
        else count_next = count - IDX_W'(1);
      end
      FN_READ: begin
        if (pos_ext >= cnt_ext) status_next = ST_OOB;
      end
      default: ;
    endcase
  end

  // rotate left wraps the first entry to the top, rotate right wraps the top entry to 0
  assign wrap = (func == FN_ROTL) ? cell_data[0] : last_chain[0];

  assign rd_chain[DEPTH]   = '0;
  assign last_chain[DEPTH] = '0;
  assign hit_chain[DEPTH]  = 1'b0;
  assign hidx_chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [IDX_W:0] I_EXT = (IDX_W + 1)'(i);
    logic [WIDTH-1:0] lower;
    logic [WIDTH-1:0] upper;
    logic [2:0]       sel;

    if (i == 0) begin : g_lo_edge
      assign lower = '0;
    end else begin : g_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_edge
      assign upper = '0;
    end else begin : g_hi
      assign upper = cell_data[i+1];
    end

    always_comb begin
      sel = SEL_HOLD;
      if (accept) begin
        case (func)
          FN_INSERT: begin
            if (ins_ok) begin
              if (I_EXT == pos_ext) sel = SEL_VALUE;
              else if (I_EXT > pos_ext && I_EXT <= cnt_ext) sel = SEL_LOWER;
            end
          end
          FN_DELETE: begin
            if (del_ok && I_EXT >= pos_ext && I_EXT + ONE_EXT < cnt_ext) sel = SEL_UPPER;
          end
          FN_ROTL: begin
            if (rot_ok) begin
              if (I_EXT + ONE_EXT < cnt_ext) sel = SEL_UPPER;
              else if (I_EXT + ONE_EXT == cnt_ext) sel = SEL_WRAP;
            end
          end
          FN_ROTR: begin
            if (rot_ok) begin
              if (i == 0) sel = SEL_WRAP;
              else if (I_EXT < cnt_ext) sel = SEL_LOWER;
            end
          end
          default: sel = SEL_HOLD;
        endcase
      end
    end

    assign ctl[i].sel      = sel;
    assign ctl[i].rd_tap   = (I_EXT == pos_ext);
    assign ctl[i].last_tap = (I_EXT + ONE_EXT == cnt_ext);
    assign ctl[i].live     = (I_EXT < cnt_ext);

    isa_cell #(
      .WIDTH  (WIDTH),
      .FIDX_W (FIDX_W),
      .IDX    (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .value       (value),
      .lower       (lower),
      .upper       (upper),
      .wrap        (wrap),
      .mask        (compare_mask),
      .rd_in       (rd_chain[i+1]),
      .rd_out      (rd_chain[i]),
      .last_in     (last_chain[i+1]),
      .last_out    (last_chain[i]),
      .hit_in      (hit_chain[i+1]),
      .hit_idx_in  (hidx_chain[i+1]),
      .hit_out     (hit_chain[i]),
      .hit_idx_out (hidx_chain[i]),
      .data        (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      compare_mask <= '1;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) compare_mask <= cfg_wr_data;
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload: load on each accepted transaction, hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_rd     <= (func == FN_READ && status_next == ST_OK) ? rd_chain[0] : '0;
      out_found  <= (func == FN_FIND) && hit_chain[0];
      out_fidx   <= (func == FN_FIND && hit_chain[0]) ? hidx_chain[0] : '0;
      out_count  <= count_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TW'({out_count, out_fidx, out_found, out_rd, out_status});

endmodule
